@@ hw/rtl/vid_pkg.sv @@
// Shared types, widths and codes for the vibration impact detector.
// Used by every module of the block; depends on nothing else.
package vid_pkg;

  localparam int SAMPLE_W           = 16;
  localparam int COEF_FRAC_BITS_DEF = 16;
  localparam int ALPHA_W            = 16;
  localparam int HP_W               = 20;
  localparam int LEVEL_W            = 20;
  localparam int TIME_W             = 32;
  localparam int HOLDOFF_W          = 16;
  localparam int CFG_W              = 20;
  localparam int CFG_IDX_W          = 3;

  localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd62259;

  // Shift-add unit of one axis lane.
  localparam int S_W    = ((SAMPLE_W > HP_W) ? SAMPLE_W : HP_W) + 2;
  localparam int MP_W   = (ALPHA_W > HP_W) ? ALPHA_W : HP_W;
  localparam int SQ_W   = 2 * HP_W;
  localparam int ACC_W  = (((S_W + ALPHA_W) > SQ_W) ? (S_W + ALPHA_W) : SQ_W) + 1;
  localparam int STEP_W = $clog2(MP_W);

  // Root extraction.
  localparam int SUM_W  = SQ_W + 2;
  localparam int ROOT_W = SUM_W / 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED   = 3'd0,
    CFG_ALPHA     = 3'd1,
    CFG_THR_LEVEL = 3'd2,
    CFG_THR_LOW   = 3'd3,
    CFG_THR_MED   = 3'd4,
    CFG_THR_HIGH  = 3'd5,
    CFG_HOLDOFF   = 3'd6
  } cfg_index_t;

  typedef enum logic [1:0] {
    THR_LOW  = 2'd0,
    THR_MED  = 2'd1,
    THR_HIGH = 2'd2
  } thr_sel_t;

  typedef enum logic [2:0] {
    LOP_IDLE,
    LOP_CLEAR,
    LOP_LOAD_MUL,
    LOP_STEP,
    LOP_FINISH_MUL,
    LOP_LOAD_SQ
  } lane_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_FIX,
    ST_SQ_LOAD,
    ST_SQ,
    ST_SUM,
    ST_ROOT,
    ST_DECIDE
  } vid_state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
    logic [TIME_W-1:0]          now_ms;
    logic                       restart;
  } vid_in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] vibration_level;
    logic               above_threshold;
    logic               lock_request;
  } vid_out_t;

endpackage

@@ hw/rtl/vid_lane.sv @@
// One axis lane: high-pass filter state and a bit-serial shift-add unit that
// forms alpha times the filter input, then the square of the filter output.
// Depends on vid_pkg.
module vid_lane #(
  parameter int COEF_FRAC_BITS = vid_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  vid_pkg::lane_op_t                    op,
  input  logic [vid_pkg::ALPHA_W-1:0]          alpha,
  input  logic signed [vid_pkg::SAMPLE_W-1:0]  x_in,
  output logic [vid_pkg::SQ_W-1:0]             sq
);
  import vid_pkg::*;

  localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] HP_MAXA = ACC_W'((1 << (HP_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] HP_MINA = -HP_MAXA - ACC_W'(1);

  logic signed [HP_W-1:0]     hp_r, hp_nxt;
  logic signed [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic signed [ACC_W-1:0]    mcand_r, mcand_nxt;
  logic [MP_W-1:0]            mplier_r, mplier_nxt;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [ACC_W-1:0]    s_in;
  logic signed [ACC_W-1:0]    rounded;
  logic signed [ACC_W-1:0]    shifted;
  logic [HP_W-1:0]            mag;

  always_comb begin
    hp_nxt     = hp_r;
    prev_nxt   = prev_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    s_in       = ACC_W'(hp_r) + ACC_W'(x_in) - ACC_W'(prev_r);
    rounded    = acc_r + RND;
    shifted    = rounded >>> COEF_FRAC_BITS;
    mag        = hp_r[HP_W-1] ? HP_W'(-hp_r) : HP_W'(hp_r);
    case (op)
      LOP_CLEAR: begin
        hp_nxt   = '0;
        prev_nxt = '0;
      end
      LOP_LOAD_MUL: begin
        mcand_nxt  = s_in;
        mplier_nxt = MP_W'(alpha);
        acc_nxt    = '0;
      end
      LOP_STEP: begin
        if (mplier_r[0]) begin
          acc_nxt = acc_r + mcand_r;
        end
        mcand_nxt  = mcand_r <<< 1;
        mplier_nxt = mplier_r >> 1;
      end
      LOP_FINISH_MUL: begin
        if (shifted > HP_MAXA) begin
          hp_nxt = HP_W'(HP_MAXA);
        end else if (shifted < HP_MINA) begin
          hp_nxt = HP_W'(HP_MINA);
        end else begin
          hp_nxt = HP_W'(shifted);
        end
        prev_nxt = x_in;
      end
      LOP_LOAD_SQ: begin
        mcand_nxt  = ACC_W'(mag);
        mplier_nxt = MP_W'(mag);
        acc_nxt    = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r   <= '0;
      prev_r <= '0;
    end else begin
      hp_r   <= hp_nxt;
      prev_r <= prev_nxt;
    end
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
  end

  assign sq = SQ_W'(acc_r);

endmodule

@@ hw/rtl/vid_isqrt.sv @@
// Digit-serial integer square root, one root bit per cycle.
// The radicand is shifted in two bits at a time. Depends on vid_pkg.
module vid_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [vid_pkg::SUM_W-1:0]    din,
  output logic [vid_pkg::ROOT_W-1:0]   root,
  output logic                         done
);
  import vid_pkg::*;

  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(ROOT_W - 1);

  logic [SUM_W-1:0]  val_r, val_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  always_comb begin
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[REM_W-3:0], val_r[SUM_W-1 -: 2]};
    trial    = REM_W'({root_r, 2'b01});
    if (start) begin
      val_nxt  = din;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      val_nxt = val_r << 2;
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == LAST) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    val_r  <= val_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root = root_r;
  assign done = done_r;

endmodule

@@ hw/rtl/vibration_impact_detector.sv @@
// Top level of the vibration impact detector: sequencer, configuration
// registers, threshold and holdoff logic. Depends on vid_pkg, vid_lane and
// vid_isqrt.
//
// Each accepted beat carries a three-axis sample and a millisecond time. The
// three axes are filtered in parallel lanes, each with one bit-serial
// shift-add unit that first forms alpha times the filter input and then the
// square of the new filter output; the root of the summed squares comes from
// a unit that yields one bit per cycle. With the block enabled a beat passes
// through the load, multiply, fix, square-load, square, sum, root and decide
// states before its result waits at the output. Disabled, a beat goes from
// the load state straight to the decide state; either way the sequencer then
// returns to idle, where the next beat is taken. in_stall is high while a beat
// is in work; a new beat is taken while the previous result still waits on
// out_stall. After reset the block is disabled, alpha is 62259, the medium
// threshold is selected and all other configuration registers are zero.
module vibration_impact_detector #(
  parameter int COEF_FRAC_BITS = vid_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  vid_pkg::vid_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output vid_pkg::vid_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [vid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vid_pkg::CFG_W-1:0]       cfg_data
);
  import vid_pkg::*;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MP_W - 1);

  logic                 enabled_r;
  logic [ALPHA_W-1:0]   alpha_r;
  logic [1:0]           thr_level_r;
  logic [LEVEL_W-1:0]   thr_low_r, thr_med_r, thr_high_r;
  logic [HOLDOFF_W-1:0] holdoff_r;

  vid_state_t           state_r, state_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  vid_in_t              in_data_r, in_data_nxt;
  logic [LEVEL_W-1:0]   level_r, level_nxt;
  logic [TIME_W-1:0]    last_exceed_r, last_exceed_nxt;
  logic                 out_valid_r, out_valid_nxt;
  vid_out_t             out_data_r, out_data_nxt;

  lane_op_t             lane_op;
  logic [SQ_W-1:0]      sq_x, sq_y, sq_z;
  logic                 sq_start;
  logic [SUM_W-1:0]     sq_sum;
  logic [ROOT_W-1:0]    root;
  logic                 root_done;
  logic                 accept;
  logic [LEVEL_W-1:0]   thr;
  logic                 above;
  logic [TIME_W-1:0]    gap;

  assign accept = in_valid && !in_stall;
  assign sq_sum = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b0;
      alpha_r     <= ALPHA_RST;
      thr_level_r <= THR_MED;
      thr_low_r   <= '0;
      thr_med_r   <= '0;
      thr_high_r  <= '0;
      holdoff_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLED:   enabled_r   <= cfg_data[0];
        CFG_ALPHA:     alpha_r     <= cfg_data[ALPHA_W-1:0];
        CFG_THR_LEVEL: thr_level_r <= cfg_data[1:0];
        CFG_THR_LOW:   thr_low_r   <= cfg_data[LEVEL_W-1:0];
        CFG_THR_MED:   thr_med_r   <= cfg_data[LEVEL_W-1:0];
        CFG_THR_HIGH:  thr_high_r  <= cfg_data[LEVEL_W-1:0];
        CFG_HOLDOFF:   holdoff_r   <= cfg_data[HOLDOFF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (thr_level_r)
      THR_LOW:  thr = thr_low_r;
      THR_HIGH: thr = thr_high_r;
      default:  thr = thr_med_r;
    endcase
    above = level_r > thr;
    gap   = in_data_r.now_ms - last_exceed_r;
  end

  always_comb begin
    state_nxt       = state_r;
    step_nxt        = step_r;
    in_data_nxt     = in_data_r;
    level_nxt       = level_r;
    last_exceed_nxt = last_exceed_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_data_nxt    = out_data_r;
    lane_op         = LOP_IDLE;
    sq_start        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          in_data_nxt = in_data;
          if (in_data.restart) begin
            lane_op         = LOP_CLEAR;
            level_nxt       = '0;
            last_exceed_nxt = '0;
          end
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (enabled_r) begin
          lane_op   = LOP_LOAD_MUL;
          step_nxt  = '0;
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_MUL: begin
        lane_op  = LOP_STEP;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_LAST) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        lane_op   = LOP_FINISH_MUL;
        state_nxt = ST_SQ_LOAD;
      end
      ST_SQ_LOAD: begin
        lane_op   = LOP_LOAD_SQ;
        step_nxt  = '0;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        lane_op  = LOP_STEP;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_LAST) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        sq_start  = 1'b1;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (root_done) begin
          if (root > ROOT_W'({LEVEL_W{1'b1}})) begin
            level_nxt = '1;
          end else begin
            level_nxt = LEVEL_W'(root);
          end
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.vibration_level = level_r;
          out_data_nxt.above_threshold = above;
          out_data_nxt.lock_request    = above && (gap >= TIME_W'(holdoff_r));
          if (above) begin
            last_exceed_nxt = in_data_r.now_ms;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      step_r        <= '0;
      level_r       <= '0;
      last_exceed_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      step_r        <= step_nxt;
      level_r       <= level_nxt;
      last_exceed_r <= last_exceed_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    in_data_r  <= in_data_nxt;
    out_data_r <= out_data_nxt;
  end

  vid_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_x (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (lane_op),
    .alpha (alpha_r),
    .x_in  (in_data_r.accel_x),
    .sq    (sq_x)
  );

  vid_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_y (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (lane_op),
    .alpha (alpha_r),
    .x_in  (in_data_r.accel_y),
    .sq    (sq_y)
  );

  vid_lane #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_lane_z (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (lane_op),
    .alpha (alpha_r),
    .x_in  (in_data_r.accel_z),
    .sq    (sq_z)
  );

  vid_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .din   (sq_sum),
    .root  (root),
    .done  (root_done)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A lock request is only ever raised together with an exceedance.
  a_lock_implies_above: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.lock_request || out_data.above_threshold))
    else $error("lock request without exceedance");

  // A restart beat clears the level and the last exceedance time.
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.restart) |=> (level_r == '0 && last_exceed_r == '0))
    else $error("restart did not clear the state");

  // The root unit finishes only while the sequencer waits for it.
  a_root_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> (state_r == ST_ROOT))
    else $error("root finished outside of its wait state");

  // A new result is loaded only when the previous one has been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_data_r == $past(out_data_r)))
    else $error("waiting result overwritten");

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the vibration impact detector: drives samples and register
// writes, predicts level, threshold and lock results in a scoreboard class.
// Depends on vid_pkg and the vibration_impact_detector top level.
`timescale 1ns / 1ps

module tb_top;
  import vid_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int PHASES = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
  localparam logic [1:0] THR_SEL_SPARE = 2'd3;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam longint HP_MAX = (longint'(1) << (HP_W - 1)) - 1;
  localparam longint HP_MIN = -(longint'(1) << (HP_W - 1));
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  class impact_scoreboard;
    bit                       enabled;
    bit [ALPHA_W-1:0]         alpha;
    bit [1:0]                 thr_sel;
    bit [LEVEL_W-1:0]         thr_low;
    bit [LEVEL_W-1:0]         thr_med;
    bit [LEVEL_W-1:0]         thr_high;
    bit [HOLDOFF_W-1:0]       holdoff;
    bit signed [SAMPLE_W-1:0] prev [3];
    bit signed [HP_W-1:0]     hp [3];
    bit [LEVEL_W-1:0]         level;
    bit [TIME_W-1:0]          last_exceed;
    vid_out_t                 expected_results [$];
    int                       errors;
    int                       checked;
    int                       locks;

    function new();
      enabled = 1'b0;
      alpha = ALPHA_RST;
      thr_sel = THR_MED;
      thr_low = '0;
      thr_med = '0;
      thr_high = '0;
      holdoff = '0;
      errors = 0;
      checked = 0;
      locks = 0;
      clear_history();
    endfunction

    function void clear_history();
      for (int ax = 0; ax < 3; ax++) begin
        prev[ax] = '0;
        hp[ax] = '0;
      end
      level = '0;
      last_exceed = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_ENABLED:   enabled = val[0];
        CFG_ALPHA:     alpha = val[ALPHA_W-1:0];
        CFG_THR_LEVEL: thr_sel = val[1:0];
        CFG_THR_LOW:   thr_low = val[LEVEL_W-1:0];
        CFG_THR_MED:   thr_med = val[LEVEL_W-1:0];
        CFG_THR_HIGH:  thr_high = val[LEVEL_W-1:0];
        CFG_HOLDOFF:   holdoff = val[HOLDOFF_W-1:0];
        default: ;
      endcase
    endfunction

    function bit signed [HP_W-1:0] high_pass(bit signed [HP_W-1:0] h,
                                             bit signed [SAMPLE_W-1:0] p,
                                             bit signed [SAMPLE_W-1:0] x);
      longint s;
      longint q;
      s = longint'(h) + longint'(x) - longint'(p);
      q = longint'(alpha) * s + (longint'(1) << (COEF_FRAC_BITS_DEF - 1));
      q = q >>> COEF_FRAC_BITS_DEF;
      if (q > HP_MAX) q = HP_MAX;
      if (q < HP_MIN) q = HP_MIN;
      return q[HP_W-1:0];
    endfunction

    function longint unsigned int_root(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function void note_sample(vid_in_t s);
      bit signed [SAMPLE_W-1:0] x [3];
      longint unsigned sum;
      longint unsigned root;
      bit [LEVEL_W-1:0] limit;
      bit [TIME_W-1:0] gap;
      vid_out_t e;
      x[0] = s.accel_x;
      x[1] = s.accel_y;
      x[2] = s.accel_z;
      if (s.restart) clear_history();
      if (enabled) begin
        sum = 0;
        for (int ax = 0; ax < 3; ax++) begin
          hp[ax] = high_pass(hp[ax], prev[ax], x[ax]);
          prev[ax] = x[ax];
          sum = sum + longint'(unsigned'(longint'(hp[ax]) * longint'(hp[ax])));
        end
        root = int_root(sum);
        level = (root > LEVEL_MAX) ? LEVEL_MAX : root[LEVEL_W-1:0];
      end
      case (thr_sel)
        THR_LOW:  limit = thr_low;
        THR_HIGH: limit = thr_high;
        default:  limit = thr_med;
      endcase
      e.vibration_level = level;
      e.above_threshold = level > limit;
      e.lock_request = 1'b0;
      if (e.above_threshold) begin
        gap = s.now_ms - last_exceed;
        if (gap >= TIME_W'(holdoff)) e.lock_request = 1'b1;
        last_exceed = s.now_ms;
      end
      if (e.lock_request) locks++;
      expected_results.push_back(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch in %s at result %0d: got %0d, expected %0d", what, checked, got, want);
      errors++;
    endtask

    task check_result(vid_out_t got);
      vid_out_t want;
      if (expected_results.size() == 0) begin
        report("unexpected beat", 32'(got.vibration_level), 32'd0);
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (got.vibration_level !== want.vibration_level)
        report("vibration_level", 32'(got.vibration_level), 32'(want.vibration_level));
      if (got.above_threshold !== want.above_threshold)
        report("above_threshold", 32'(got.above_threshold), 32'(want.above_threshold));
      if (got.lock_request !== want.lock_request)
        report("lock_request", 32'(got.lock_request), 32'(want.lock_request));
    endtask

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  vid_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  vid_out_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  impact_scoreboard sb;
  bit               calm = 1'b0;
  int               cycles = 0;
  int               n_sent = 0;
  int               n_setups = 0;
  bit [TIME_W-1:0]  clock_ms = '0;

  vibration_impact_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 21);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Unused upper data bits carry noise; the block must ignore them.
  task automatic load_setup(input bit en, input bit [ALPHA_W-1:0] a, input bit [1:0] sel,
                            input bit [LEVEL_W-1:0] lo, input bit [LEVEL_W-1:0] med,
                            input bit [LEVEL_W-1:0] hi, input bit [HOLDOFF_W-1:0] hold);
    write_reg(CFG_ENABLED, (CFG_W'($urandom()) << 1) | CFG_W'(en));
    write_reg(CFG_ALPHA, {4'($urandom()), a});
    write_reg(CFG_THR_LEVEL, {18'($urandom()), sel});
    write_reg(CFG_THR_LOW, lo);
    write_reg(CFG_THR_MED, med);
    write_reg(CFG_THR_HIGH, hi);
    write_reg(CFG_HOLDOFF, {4'($urandom()), hold});
    write_reg(CFG_SPARE_IDX, CFG_W'($urandom()));
    cfg_we <= 1'b0;
    n_setups++;
  endtask

  task automatic idle_gap();
    int n;
    if (!calm && $urandom_range(99) < 21) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_sample(input vid_in_t s);
    idle_gap();
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (in_stall);
    sb.note_sample(s);
    n_sent++;
  endtask

  task automatic send_fields(input logic signed [SAMPLE_W-1:0] x,
                             input logic signed [SAMPLE_W-1:0] y,
                             input logic signed [SAMPLE_W-1:0] z,
                             input logic [TIME_W-1:0] now, input logic restart);
    vid_in_t s;
    s.accel_x = x;
    s.accel_y = y;
    s.accel_z = z;
    s.now_ms = now;
    s.restart = restart;
    send_sample(s);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_axis(int kind);
    case (kind)
      0: return SAMPLE_W'($urandom_range(0, 512)) - 16'sd256;
      1: return SAMPLE_W'($urandom());
      default: begin
        case ($urandom_range(2))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          default: return SAMPLE_W'($urandom());
        endcase
      end
    endcase
  endfunction

  function automatic vid_in_t random_sample();
    vid_in_t s;
    int kind;
    int r;
    r = $urandom_range(99);
    kind = (r < 40) ? 0 : ((r < 75) ? 1 : 2);
    s.accel_x = pick_axis(kind);
    s.accel_y = pick_axis(kind);
    s.accel_z = pick_axis(kind);
    clock_ms = clock_ms + $urandom_range(0, 40);
    if ($urandom_range(49) == 0) clock_ms = $urandom();
    s.now_ms = clock_ms;
    s.restart = ($urandom_range(99) < 3);
    return s;
  endfunction

  function automatic bit [LEVEL_W-1:0] pick_limit();
    case ($urandom_range(4))
      0: return '0;
      1: return LEVEL_MAX;
      2: return LEVEL_W'($urandom_range(0, 3000));
      3: return LEVEL_W'($urandom_range(0, 400000));
      default: return LEVEL_W'($urandom());
    endcase
  endfunction

  function automatic bit [HOLDOFF_W-1:0] pick_holdoff();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return HOLDOFF_W'($urandom_range(0, 300));
      default: return HOLDOFF_W'($urandom());
    endcase
  endfunction

  initial begin
    bit [ALPHA_W-1:0] a;
    bit [HOLDOFF_W-1:0] hold;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setup: disabled, so the level stays at zero.
    send_fields(SAMPLE_MAX, SAMPLE_MIN, 16'sd0, 32'd0, 1'b0);
    send_fields(SAMPLE_MIN, SAMPLE_MAX, 16'sd1, 32'd5, 1'b1);
    drain();

    // Full-scale swings drive the filters to large outputs; the first exceedance
    // comes before the holdoff has elapsed since time zero.
    load_setup(1'b1, 16'hFFFF, THR_LOW, 20'd1000, LEVEL_MAX, LEVEL_MAX, 16'd50);
    send_fields(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 32'd10, 1'b0);
    send_fields(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 32'd30, 1'b0);
    for (int k = 0; k < 8; k++)
      send_fields(k[0] ? SAMPLE_MIN : SAMPLE_MAX, k[0] ? SAMPLE_MAX : SAMPLE_MIN,
                  k[0] ? SAMPLE_MIN : SAMPLE_MAX, 32'(90 + 60 * k), 1'b0);
    send_fields(16'sd0, 16'sd0, 16'sd0, 32'd1000, 1'b1);
    send_fields(16'sd0, 16'sd0, 16'sd0, 32'd1001, 1'b0);
    send_fields(SAMPLE_MAX, 16'sd0, SAMPLE_MIN, 32'hFFFF_FFF0, 1'b0);
    send_fields(SAMPLE_MIN, SAMPLE_MAX, 16'sd0, 32'h0000_0010, 1'b0);
    drain();

    // Disabled with a held level above a zero medium threshold, then a restart.
    load_setup(1'b0, 16'd1234, THR_SEL_SPARE, LEVEL_MAX, 20'd0, LEVEL_MAX, 16'd0);
    send_fields(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 32'd20, 1'b0);
    send_fields(16'sd7, 16'sd7, 16'sd7, 32'd21, 1'b0);
    send_fields(16'sd7, 16'sd7, 16'sd7, 32'd22, 1'b1);
    drain();

    load_setup(1'b1, 16'd0, THR_HIGH, LEVEL_MAX, LEVEL_MAX, 20'd0, 16'hFFFF);
    send_fields(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 32'd100, 1'b0);
    send_fields(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 32'd200, 1'b0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: a = '1;
        1: a = '0;
        2: a = ALPHA_RST;
        default: a = ALPHA_W'($urandom());
      endcase
      case (ph)
        0: hold = '0;
        1: hold = '1;
        default: hold = pick_holdoff();
      endcase
      calm = (ph == 3);
      load_setup(ph != 5, a, 2'(ph % 4), pick_limit(), pick_limit(), pick_limit(), hold);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) send_sample(random_sample());
      drain();
    end
    calm = 1'b0;

    repeat (80) @(posedge clk);
    $display("Covered %0d samples and %0d checked beats over %0d register setups,", n_sent,
             sb.checked, n_setups);
    $display("with restarts, disabled holds, all threshold selects and %0d lock requests.",
             sb.locks);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/vid_pkg.sv
hw/rtl/vid_lane.sv
hw/rtl/vid_isqrt.sv
hw/rtl/vibration_impact_detector.sv
bench/tb_top.sv
